### hdl/ima4_pkg.sv
// ----------------------------------------------------------------------------
// ima4_pkg
// Shared types, constants and table functions for the IMA4 block decoder.
// ----------------------------------------------------------------------------
package ima4_pkg;

   localparam int unsigned MAX_STEP_IDX = 88;

   typedef logic [6:0]  step_idx_type;
   typedef logic [14:0] step_size_type;
   typedef logic [5:0]  byte_pos_type;

   // Byte positions inside a block: the two header bytes and the first data byte
   localparam byte_pos_type POS_HEADER_HIGH = 6'd0;
   localparam byte_pos_type POS_HEADER_LOW  = 6'd1;
   localparam byte_pos_type POS_FIRST_DATA  = 6'd2;

   localparam step_idx_type STEP_IDX_MAX = step_idx_type'(MAX_STEP_IDX);

   localparam step_size_type STEP_SIZE_TABLE [0:MAX_STEP_IDX] = '{
      15'd7,     15'd8,     15'd9,     15'd10,    15'd11,
      15'd12,    15'd13,    15'd14,    15'd16,    15'd17,
      15'd19,    15'd21,    15'd23,    15'd25,    15'd28,
      15'd31,    15'd34,    15'd37,    15'd41,    15'd45,
      15'd50,    15'd55,    15'd60,    15'd66,    15'd73,
      15'd80,    15'd88,    15'd97,    15'd107,   15'd118,
      15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
      15'd209,   15'd230,   15'd253,   15'd279,   15'd307,
      15'd337,   15'd371,   15'd408,   15'd449,   15'd494,
      15'd544,   15'd598,   15'd658,   15'd724,   15'd796,
      15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,
      15'd1411,  15'd1552,  15'd1707,  15'd1878,  15'd2066,
      15'd2272,  15'd2499,  15'd2749,  15'd3024,  15'd3327,
      15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
      15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,
      15'd9493,  15'd10442, 15'd11487, 15'd12635, 15'd13899,
      15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385,
      15'd24623, 15'd27086, 15'd29794, 15'd32767
   };

   // Clamp a step index to the top of the table
   function automatic step_idx_type clamp_index(input step_idx_type idx);
      step_idx_type res;
      res = (idx > STEP_IDX_MAX) ? STEP_IDX_MAX : idx;
      return res;
   endfunction

   // Look up the step size for an index, clamping out-of-range indexes
   function automatic step_size_type step_size(input step_idx_type idx);
      step_size_type res;
      res = STEP_SIZE_TABLE[clamp_index(idx)];
      return res;
   endfunction

   // Next step index from the nibble magnitude bits, clamped to 0..88
   function automatic step_idx_type next_index(input step_idx_type idx,
                                               input logic [2:0]   mag);
      step_idx_type cur;
      logic [7:0]   sum;
      step_idx_type res;
      cur = clamp_index(idx);
      sum = {1'b0, cur} + {4'd0, {1'b0, mag[1:0]} + 3'd1, 1'b0};
      if (!mag[2]) begin
         res = (cur == '0) ? '0 : cur - 7'd1;
      end else if (sum > {1'b0, STEP_IDX_MAX}) begin
         res = STEP_IDX_MAX;
      end else begin
         res = sum[6:0];
      end
      return res;
   endfunction

endpackage

### hdl/ima4_channels.sv
// ----------------------------------------------------------------------------
// ima4_channels
// Valid/ready channel interfaces for the IMA4 decoder byte and sample streams.
// ----------------------------------------------------------------------------
interface ima4_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface ima4_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;
   logic               last_of_pair;
   logic               end_of_block;

   modport source (output valid, output sample, output last_of_pair,
                   output end_of_block, input ready);
   modport sink   (input valid, input sample, input last_of_pair,
                   input end_of_block, output ready);
endinterface

### hdl/ima4_adpcm_block_decoder.sv
// ----------------------------------------------------------------------------
// ima4_adpcm_block_decoder
// IMA4 ADPCM block decoder: bytes in, signed 16-bit PCM samples out.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one block byte per beat: two header bytes, then
//   DATA_BYTES data bytes, then the next block's header. rsp_chan carries
//   one sample per beat, low nibble first; last_of_pair marks the second
//   sample of a byte and end_of_block the final sample of the block.
//   Header bytes produce no samples.
// Timing:
//   An accepted byte lands in a holding register. A header byte is absorbed
//   the next cycle. A data byte occupies the single nibble decoder for both
//   of its nibbles, one sample per cycle into the output register while
//   rsp_chan does not stall. The next byte is accepted as the second
//   sample of the current one is written; the shared nibble decoder and
//   the one-sample-wide result channel set the throughput.
// Reset and stall:
//   Synchronous reset empties both registers and starts a new block at its
//   first header byte. While rsp_chan stalls the output register holds its
//   sample and the holding register holds its data byte; req_chan.ready drops
//   once the holding register cannot drain.
// ----------------------------------------------------------------------------
module ima4_adpcm_block_decoder
   import ima4_pkg::*;
#(
   parameter int unsigned DATA_BYTES = 32
) (
   input  logic              clock,
   input  logic              reset,
   ima4_req_if.sink          req_chan,
   ima4_rsp_if.source        rsp_chan
);

   localparam byte_pos_type LAST_POS = byte_pos_type'(DATA_BYTES + 1);

   // Holding register
   logic         hold_valid_ff, hold_valid_in;
   logic [7:0]   hold_byte_ff, hold_byte_in;
   logic         hold_phase_ff, hold_phase_in;

   // Decoder state
   logic [15:0]  predictor_ff, predictor_in;
   step_idx_type step_pos_ff, step_pos_in;
   byte_pos_type byte_pos_ff, byte_pos_in;
   logic [7:0]   header_high_ff, header_high_in;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] sample_ff, sample_in;
   logic               last_of_pair_ff, last_of_pair_in;
   logic               end_of_block_ff, end_of_block_in;

   // Nibble datapath
   logic [3:0]         nibble;
   logic [16:0]        step_ext;
   logic [16:0]        diff;
   logic signed [17:0] pred_wide;
   logic signed [17:0] sum_wide;
   logic [15:0]        sat_value;

   logic out_free;
   logic is_header;
   logic emit;
   logic consume;
   logic req_fire;

   // Decode the selected nibble against the current state
   always_comb begin
      nibble    = hold_phase_ff ? hold_byte_ff[7:4] : hold_byte_ff[3:0];
      step_ext  = {2'b00, step_size(step_pos_ff)};
      diff      = (step_ext >> 3)
                + (nibble[2] ? step_ext : 17'd0)
                + (nibble[1] ? (step_ext >> 1) : 17'd0)
                + (nibble[0] ? (step_ext >> 2) : 17'd0);
      pred_wide = {{2{predictor_ff[15]}}, predictor_ff};
      if (nibble[3]) begin
         sum_wide = pred_wide - $signed({1'b0, diff});
      end else begin
         sum_wide = pred_wide + $signed({1'b0, diff});
      end
      if (sum_wide > 18'sd32767) begin
         sat_value = 16'h7FFF;
      end else if (sum_wide < -18'sd32768) begin
         sat_value = 16'h8000;
      end else begin
         sat_value = sum_wide[15:0];
      end
   end

   // Sequence header absorption, nibble emission and byte handoff
   always_comb begin
      out_free  = !rsp_valid_ff || rsp_chan.ready;
      is_header = (byte_pos_ff == POS_HEADER_HIGH) || (byte_pos_ff == POS_HEADER_LOW);
      emit      = hold_valid_ff && !is_header && out_free;
      consume   = hold_valid_ff && (is_header || (emit && hold_phase_ff));
      req_chan.ready = !hold_valid_ff || consume;
      req_fire  = req_chan.valid && req_chan.ready;

      hold_valid_in  = hold_valid_ff;
      hold_byte_in   = hold_byte_ff;
      hold_phase_in  = hold_phase_ff;
      predictor_in   = predictor_ff;
      step_pos_in    = step_pos_ff;
      byte_pos_in    = byte_pos_ff;
      header_high_in = header_high_ff;

      rsp_valid_in    = rsp_chan.ready ? 1'b0 : rsp_valid_ff;
      sample_in       = sample_ff;
      last_of_pair_in = last_of_pair_ff;
      end_of_block_in = end_of_block_ff;

      // Absorb header bytes into the state
      if (hold_valid_ff && byte_pos_ff == POS_HEADER_HIGH) begin
         header_high_in = hold_byte_ff;
         byte_pos_in    = POS_HEADER_LOW;
      end else if (hold_valid_ff && byte_pos_ff == POS_HEADER_LOW) begin
         predictor_in = {header_high_ff, hold_byte_ff[7], 7'd0};
         step_pos_in  = clamp_index(hold_byte_ff[6:0]);
         byte_pos_in  = POS_FIRST_DATA;
      end

      // Emit one sample and advance the decoder state
      if (emit) begin
         predictor_in    = sat_value;
         step_pos_in     = next_index(step_pos_ff, nibble[2:0]);
         rsp_valid_in    = 1'b1;
         sample_in       = $signed(sat_value);
         last_of_pair_in = hold_phase_ff;
         end_of_block_in = hold_phase_ff && (byte_pos_ff >= LAST_POS);
         hold_phase_in   = !hold_phase_ff;
         if (hold_phase_ff) begin
            byte_pos_in = (byte_pos_ff >= LAST_POS) ? POS_HEADER_HIGH
                                                    : byte_pos_ff + 6'd1;
         end
      end

      // Drop a finished byte and load the next beat
      if (consume) begin
         hold_valid_in = 1'b0;
         hold_phase_in = 1'b0;
      end
      if (req_fire) begin
         hold_valid_in = 1'b1;
         hold_byte_in  = req_chan.data_byte;
         hold_phase_in = 1'b0;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff  <= 1'b0;
         hold_phase_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         predictor_ff   <= '0;
         step_pos_ff    <= '0;
         byte_pos_ff    <= POS_HEADER_HIGH;
         header_high_ff <= '0;
      end else begin
         hold_valid_ff  <= hold_valid_in;
         hold_phase_ff  <= hold_phase_in;
         rsp_valid_ff   <= rsp_valid_in;
         predictor_ff   <= predictor_in;
         step_pos_ff    <= step_pos_in;
         byte_pos_ff    <= byte_pos_in;
         header_high_ff <= header_high_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      hold_byte_ff    <= hold_byte_in;
      sample_ff       <= sample_in;
      last_of_pair_ff <= last_of_pair_in;
      end_of_block_ff <= end_of_block_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.sample       = sample_ff;
   assign rsp_chan.last_of_pair = last_of_pair_ff;
   assign rsp_chan.end_of_block = end_of_block_ff;

endmodule
